FILE: design/dqne_pkg.sv
// Shared types and constants for the DNS query name extractor.
`default_nettype none

package dqne_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_WATCHED_PORT = 2'd0;
    localparam logic [1:0] CFG_LINK_BYTES   = 2'd1;
    localparam logic [1:0] CFG_MAX_LABELS   = 2'd2;

    localparam logic [15:0] RST_WATCHED_PORT = 16'd53;
    localparam logic [6:0]  RST_LINK_BYTES   = 7'd14;
    localparam logic [3:0]  RST_MAX_LABELS   = 4'd5;

    localparam int OUT_TOTAL_W = 48;

    localparam logic [3:0]  IP_VER6      = 4'd6;
    localparam logic [3:0]  IHL_MIN      = 4'd5;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [7:0]  PROTO_ROUTE  = 8'd43;
    localparam logic [7:0]  PROTO_FRAG   = 8'd44;
    localparam logic [7:0]  PROTO_ESP    = 8'd50;
    localparam logic [7:0]  PROTO_AH     = 8'd51;
    localparam logic [7:0]  PROTO_DSTOPT = 8'd60;

    localparam logic [7:0]  CHAR_DOT   = 8'd46;
    localparam logic [7:0]  CHAR_SLASH = 8'd47;

    localparam logic [11:0] IP6_HDR_BYTES  = 12'd40;
    localparam logic [11:0] EXT_MIN_BYTES  = 12'd8;
    localparam logic [11:0] UDP_HDR_BYTES  = 12'd8;
    localparam logic [11:0] DNS_HDR_BYTES  = 12'd12;
    localparam logic [11:0] TAIL_BYTES     = 12'd4;
    localparam logic [11:0] OFS_IP4_PROTO  = 12'd9;
    localparam logic [11:0] OFS_IP6_NEXT   = 12'd6;
    localparam logic [11:0] OFS_PORT_HI    = 12'd2;
    localparam logic [11:0] OFS_PORT_LO    = 12'd3;
    localparam logic [11:0] OFS_QD_HI      = 12'd4;
    localparam logic [11:0] OFS_QD_LO      = 12'd5;
    localparam logic [3:0]  LABELS_CAP     = 4'd15;

    // One result item
    typedef struct packed {
        logic        kind;
        logic [7:0]  char_value;
        logic        is_dns;
        logic [3:0]  ip_version;
        logic [OUT_TOTAL_W-1:0] byte_total;
        logic        last;
    } t_result;

    function automatic logic is_ext_header(input logic [7:0] p);
        return (p == PROTO_ROUTE) || (p == PROTO_FRAG) || (p == PROTO_ESP) ||
               (p == PROTO_AH) || (p == PROTO_DSTOPT);
    endfunction

endpackage

`default_nettype wire

FILE: design/dns_query_name_extractor.sv
// Top level: frame byte parser that extracts DNS question names.
// Results go into a four-entry result queue as their input beats are accepted and
// leave it on the master side at one per cycle while m_axis_tready is high.
// Up to two results per beat; one beat is taken per cycle while the queue has room.
// The slave side stalls only while that queue has fewer than two free places.
// Reset is synchronous and active low; it restores the register defaults.
`default_nettype none

module dns_query_name_extractor #(
    parameter int TOTAL_BITS = 48
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // frame_byte
    input  wire         s_axis_tlast,   // frame_end
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // char_value[7:0], is_dns[8], ip_version[12:9], byte_total[60:13], zeros
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tuser,   // kind
    output logic        m_axis_tlast,   // last
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data
);

    typedef enum logic [3:0] {
        PH_LINK, PH_IP4, PH_IP6, PH_EXT, PH_UDP,
        PH_DNSHDR, PH_LEN, PH_LABEL, PH_TAIL, PH_IDLE
    } t_phase;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [15:0] r_watched_port;
    logic [6:0]  r_link_bytes;
    logic [3:0]  r_max_labels;

    t_phase      r_phase, n_phase;
    logic [11:0] r_offset, n_offset;
    logic [11:0] r_section_end, n_section_end;
    logic [7:0]  r_next_proto, n_next_proto;
    logic [3:0]  r_version, n_version;
    logic [15:0] r_port, n_port;
    logic [15:0] r_questions, n_questions;
    logic [7:0]  r_label_left, n_label_left;
    logic [3:0]  r_labels_seen, n_labels_seen;
    logic        r_dns_flag, n_dns_flag;
    logic [TOTAL_BITS-1:0] r_running, n_running;

    dqne_pkg::t_result r_queue [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    logic        accept, pop;
    logic        ch_valid;
    logic [7:0]  ch_value;
    logic        after_hdr;
    logic [11:0] offset_inc;
    logic [11:0] ihl_bytes;
    logic [3:0]  ihl;
    logic [7:0]  label_dec;
    logic [15:0] questions_dec;
    logic [63:0] total_ext;
    dqne_pkg::t_result char_res, sum_res;
    logic [1:0]  push_n;

    assign s_axis_tready = (r_count <= CNT_W'(DEPTH - 2));
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_count != '0);
    assign pop           = m_axis_tvalid && m_axis_tready;

    // Byte parser: next state from the current state and the accepted byte.
    always_comb begin
        n_phase       = r_phase;
        n_offset      = r_offset;
        n_section_end = r_section_end;
        n_next_proto  = r_next_proto;
        n_version     = r_version;
        n_port        = r_port;
        n_questions   = r_questions;
        n_label_left  = r_label_left;
        n_labels_seen = r_labels_seen;
        n_dns_flag    = r_dns_flag;
        ch_valid      = 1'b0;
        ch_value      = s_axis_tdata;
        after_hdr     = 1'b0;
        offset_inc    = r_offset + 12'd1;
        ihl           = (s_axis_tdata[3:0] < dqne_pkg::IHL_MIN) ? dqne_pkg::IHL_MIN
                                                                : s_axis_tdata[3:0];
        ihl_bytes     = {6'd0, ihl, 2'b00};
        label_dec     = r_label_left - 8'd1;
        questions_dec = r_questions - 16'd1;

        n_running = (r_running != '1) ? r_running + TOTAL_BITS'(1) : r_running;

        unique case (r_phase)
            PH_LINK: begin
                if (r_offset < {5'd0, r_link_bytes}) begin
                    n_offset = offset_inc;
                end else begin
                    n_version = s_axis_tdata[7:4];
                    n_offset  = 12'd1;
                    if (s_axis_tdata[7:4] == dqne_pkg::IP_VER6) begin
                        n_phase = PH_IP6;
                    end else begin
                        n_section_end = ihl_bytes;
                        n_phase       = PH_IP4;
                    end
                end
            end
            PH_IP4: begin
                if (r_offset == dqne_pkg::OFS_IP4_PROTO) n_next_proto = s_axis_tdata;
                n_offset = offset_inc;
                if (offset_inc >= r_section_end) after_hdr = 1'b1;
            end
            PH_IP6: begin
                if (r_offset == dqne_pkg::OFS_IP6_NEXT) n_next_proto = s_axis_tdata;
                n_offset = offset_inc;
                if (offset_inc >= dqne_pkg::IP6_HDR_BYTES) after_hdr = 1'b1;
            end
            PH_EXT: begin
                if (r_offset == 12'd0) begin
                    n_next_proto = s_axis_tdata;
                end else if (r_offset == 12'd1) begin
                    n_section_end = {1'b0, s_axis_tdata, 3'b000} + dqne_pkg::EXT_MIN_BYTES;
                end
                n_offset = offset_inc;
                if (offset_inc >= n_section_end) after_hdr = 1'b1;
            end
            PH_UDP: begin
                if (r_offset == dqne_pkg::OFS_PORT_HI) begin
                    n_port = {s_axis_tdata, 8'h00};
                end else if (r_offset == dqne_pkg::OFS_PORT_LO) begin
                    n_port     = {r_port[15:8], s_axis_tdata};
                    n_dns_flag = ({r_port[15:8], s_axis_tdata} == r_watched_port);
                end
                n_offset = offset_inc;
                if (offset_inc >= dqne_pkg::UDP_HDR_BYTES) begin
                    n_offset = 12'd0;
                    n_phase  = n_dns_flag ? PH_DNSHDR : PH_IDLE;
                end
            end
            PH_DNSHDR: begin
                if (r_offset == dqne_pkg::OFS_QD_HI) begin
                    n_questions = {s_axis_tdata, 8'h00};
                end else if (r_offset == dqne_pkg::OFS_QD_LO) begin
                    n_questions = {r_questions[15:8], s_axis_tdata};
                end
                n_offset = offset_inc;
                if (offset_inc >= dqne_pkg::DNS_HDR_BYTES) begin
                    n_offset      = 12'd0;
                    n_labels_seen = 4'd0;
                    n_phase       = (n_questions != 16'd0) ? PH_LEN : PH_IDLE;
                end
            end
            PH_LEN: begin
                if (s_axis_tdata == 8'd0) begin
                    n_offset = 12'd0;
                    n_phase  = PH_TAIL;
                end else begin
                    n_label_left = s_axis_tdata;
                    if ((r_labels_seen != 4'd0) && (r_labels_seen < r_max_labels)) begin
                        ch_valid = 1'b1;
                        ch_value = dqne_pkg::CHAR_DOT;
                    end
                    n_phase = PH_LABEL;
                end
            end
            PH_LABEL: begin
                if (r_labels_seen < r_max_labels) ch_valid = 1'b1;
                n_label_left = label_dec;
                if (label_dec == 8'd0) begin
                    if (r_labels_seen < dqne_pkg::LABELS_CAP) begin
                        n_labels_seen = r_labels_seen + 4'd1;
                    end
                    n_phase = PH_LEN;
                end
            end
            PH_TAIL: begin
                n_offset = offset_inc;
                if (offset_inc >= dqne_pkg::TAIL_BYTES) begin
                    n_offset      = 12'd0;
                    n_labels_seen = 4'd0;
                    n_questions   = questions_dec;
                    if (questions_dec != 16'd0) begin
                        ch_valid = 1'b1;
                        ch_value = dqne_pkg::CHAR_SLASH;
                        n_phase  = PH_LEN;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: begin
            end
        endcase

        // End of the IP header or of an extension header.
        if (after_hdr) begin
            n_offset = 12'd0;
            if ((r_version == dqne_pkg::IP_VER6) && dqne_pkg::is_ext_header(n_next_proto)) begin
                n_phase       = PH_EXT;
                n_section_end = dqne_pkg::EXT_MIN_BYTES;
            end else if (n_next_proto == dqne_pkg::PROTO_UDP) begin
                n_phase = PH_UDP;
            end else begin
                n_phase = PH_IDLE;
            end
        end

        total_ext = 64'(n_running);

        char_res            = '0;
        char_res.char_value = ch_value;

        sum_res            = '0;
        sum_res.kind       = 1'b1;
        sum_res.is_dns     = n_dns_flag;
        sum_res.ip_version = n_version;
        sum_res.byte_total = total_ext[dqne_pkg::OUT_TOTAL_W-1:0];
        sum_res.last       = 1'b1;

        push_n = accept ? ({1'b0, ch_valid} + {1'b0, s_axis_tlast}) : 2'd0;
        n_count = r_count + CNT_W'(push_n) - CNT_W'(pop);
    end

    // Parser state, configuration and queue control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_watched_port <= dqne_pkg::RST_WATCHED_PORT;
            r_link_bytes   <= dqne_pkg::RST_LINK_BYTES;
            r_max_labels   <= dqne_pkg::RST_MAX_LABELS;
            r_phase        <= PH_LINK;
            r_offset       <= '0;
            r_section_end  <= '0;
            r_next_proto   <= '0;
            r_version      <= '0;
            r_port         <= '0;
            r_questions    <= '0;
            r_label_left   <= '0;
            r_labels_seen  <= '0;
            r_dns_flag     <= 1'b0;
            r_running      <= '0;
            r_wr_ptr       <= '0;
            r_rd_ptr       <= '0;
            r_count        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    dqne_pkg::CFG_WATCHED_PORT: r_watched_port <= i_cfg_data;
                    dqne_pkg::CFG_LINK_BYTES:   r_link_bytes   <= i_cfg_data[6:0];
                    dqne_pkg::CFG_MAX_LABELS:   r_max_labels   <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_running <= n_running;
                if (s_axis_tlast) begin
                    // Every frame starts from a clean parser.
                    r_phase       <= PH_LINK;
                    r_offset      <= '0;
                    r_section_end <= '0;
                    r_next_proto  <= '0;
                    r_version     <= '0;
                    r_port        <= '0;
                    r_questions   <= '0;
                    r_label_left  <= '0;
                    r_labels_seen <= '0;
                    r_dns_flag    <= 1'b0;
                end else begin
                    r_phase       <= n_phase;
                    r_offset      <= n_offset;
                    r_section_end <= n_section_end;
                    r_next_proto  <= n_next_proto;
                    r_version     <= n_version;
                    r_port        <= n_port;
                    r_questions   <= n_questions;
                    r_label_left  <= n_label_left;
                    r_labels_seen <= n_labels_seen;
                    r_dns_flag    <= n_dns_flag;
                end
            end
            r_wr_ptr <= r_wr_ptr + PTR_W'(push_n);
            if (pop) r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            r_count <= n_count;
        end
    end

    // Result queue storage; a character always goes ahead of the summary.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (ch_valid) begin
                r_queue[r_wr_ptr] <= char_res;
                if (s_axis_tlast) r_queue[r_wr_ptr + PTR_W'(1)] <= sum_res;
            end else if (s_axis_tlast) begin
                r_queue[r_wr_ptr] <= sum_res;
            end
        end
    end

    dqne_pkg::t_result head;

    always_comb begin
        head          = r_queue[r_rd_ptr];
        m_axis_tdata  = {3'b000, head.byte_total, head.ip_version, head.is_dns,
                         head.char_value};
        m_axis_tuser  = head.kind;
        m_axis_tlast  = head.last;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_count == '0))
        else $error("queue not empty after reset");

    a_kind_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == m_axis_tlast))
        else $error("summary and last flag disagree");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=>
            (r_phase == PH_LINK) && (r_offset == '0))
        else $error("parser not restarted after frame end");
`endif

endmodule

`default_nettype wire

FILE: test/dns_query_name_extractor_tb.sv
// Self-checking testbench for the DNS query name extractor: frame stimulus, byte parser model.
`timescale 1ns / 100ps

module dns_query_name_extractor_tb;

    localparam int          TOTAL_W        = 48;
    localparam logic [63:0] TOTAL_MAX      = (64'd1 << TOTAL_W) - 64'd1;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [3:0]  IP_VER4        = 4'd4;

    typedef enum logic [3:0] {
        ST_LINK, ST_IPV4, ST_IPV6, ST_EXTHDR, ST_UDPHDR, ST_DNSHDR,
        ST_LABEL_LEN, ST_LABEL_BODY, ST_QTAIL, ST_DONE
    } t_parse_state;

    typedef struct packed {
        logic [7:0] data;
        logic       eof;
    } t_beat;

    typedef struct packed {
        logic [3:0]  ver;
        logic [3:0]  ihl;
        int          n_ext;
        logic [7:0]  proto;
        logic [15:0] port;
        logic [15:0] qd;
        int          n_names;
        int          n_labels;   // negative picks a random count per name
        int          len_lo;
        int          len_hi;
        int          cut;        // 0 keeps the whole frame
    } t_frame_spec;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;  // frame_byte
    logic        s_axis_tlast = 1'b0; // frame_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // char_value[7:0], is_dns[8], ip_version[12:9], byte_total[60:13], zeros
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;        // kind
    logic        m_axis_tlast;        // last
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    dns_query_name_extractor #(.TOTAL_BITS(TOTAL_W)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Register copies, used both by the parser model and the frame builder
    logic [15:0] cfg_port       = dqne_pkg::RST_WATCHED_PORT;
    logic [6:0]  cfg_link       = dqne_pkg::RST_LINK_BYTES;
    logic [3:0]  cfg_max_labels = dqne_pkg::RST_MAX_LABELS;

    // Parser model state
    t_parse_state parse_state       = ST_LINK;
    logic [11:0]  hdr_pos           = '0;
    logic [11:0]  hdr_len           = '0;
    logic [7:0]   proto_next        = '0;
    logic [3:0]   ip_ver            = '0;
    logic [15:0]  dst_port          = '0;
    logic [15:0]  questions_pending = '0;
    logic [7:0]   label_bytes_left  = '0;
    logic [3:0]   label_count       = '0;
    logic         dns_match         = 1'b0;
    logic [63:0]  bytes_seen        = '0;

    dqne_pkg::t_result expected_results_q[$];
    t_beat   frame_bytes_q[$];
    t_beat   cur_beat;
    int      stim_bytes     = 0;
    int      accepted_bytes = 0;
    int      mismatch_count = 0;
    int      tx_gap         = 0;
    int      rx_stall       = 0;
    int      tx_gap_pct     = 20;
    int      rx_stall_pct   = 20;
    int      idle_cycles    = 0;

    function automatic int draw_gap(input int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    function automatic logic [7:0] ext_code(input int k);
        case (k % 5)
            0: return dqne_pkg::PROTO_ROUTE;
            1: return dqne_pkg::PROTO_FRAG;
            2: return dqne_pkg::PROTO_ESP;
            3: return dqne_pkg::PROTO_AH;
            default: return dqne_pkg::PROTO_DSTOPT;
        endcase
    endfunction

    // Decides what follows an IP header or an extension header.
    task automatic leave_ip_header();
        hdr_pos = '0;
        if (ip_ver == dqne_pkg::IP_VER6 &&
            (proto_next == dqne_pkg::PROTO_ROUTE || proto_next == dqne_pkg::PROTO_FRAG ||
             proto_next == dqne_pkg::PROTO_ESP || proto_next == dqne_pkg::PROTO_AH ||
             proto_next == dqne_pkg::PROTO_DSTOPT)) begin
            parse_state = ST_EXTHDR;
            hdr_len = dqne_pkg::EXT_MIN_BYTES;
        end else if (proto_next == dqne_pkg::PROTO_UDP) begin
            parse_state = ST_UDPHDR;
        end else begin
            parse_state = ST_DONE;
        end
    endtask

    // Advances the parser by one frame byte and queues the results it causes.
    task automatic parse_frame_byte(input logic [7:0] b, input logic eof);
        dqne_pkg::t_result r;
        logic       emit;
        logic [7:0] ch;
        emit = 1'b0;
        ch = '0;
        if (bytes_seen < TOTAL_MAX)
            bytes_seen++;
        case (parse_state)
            ST_LINK: begin
                if (hdr_pos < {5'd0, cfg_link}) begin
                    hdr_pos++;
                end else begin
                    ip_ver = b[7:4];
                    hdr_pos = 12'd1;
                    if (ip_ver == dqne_pkg::IP_VER6) begin
                        parse_state = ST_IPV6;
                    end else begin
                        hdr_len = {8'd0, b[3:0]};
                        if (hdr_len < {8'd0, dqne_pkg::IHL_MIN})
                            hdr_len = {8'd0, dqne_pkg::IHL_MIN};
                        hdr_len = hdr_len << 2;
                        parse_state = ST_IPV4;
                    end
                end
            end
            ST_IPV4: begin
                if (hdr_pos == dqne_pkg::OFS_IP4_PROTO)
                    proto_next = b;
                hdr_pos++;
                if (hdr_pos >= hdr_len)
                    leave_ip_header();
            end
            ST_IPV6: begin
                if (hdr_pos == dqne_pkg::OFS_IP6_NEXT)
                    proto_next = b;
                hdr_pos++;
                if (hdr_pos >= dqne_pkg::IP6_HDR_BYTES)
                    leave_ip_header();
            end
            ST_EXTHDR: begin
                if (hdr_pos == 12'd0)
                    proto_next = b;
                else if (hdr_pos == 12'd1)
                    hdr_len = dqne_pkg::EXT_MIN_BYTES + {1'b0, b, 3'b000};
                hdr_pos++;
                if (hdr_pos >= hdr_len)
                    leave_ip_header();
            end
            ST_UDPHDR: begin
                if (hdr_pos == dqne_pkg::OFS_PORT_HI) begin
                    dst_port = {b, 8'h00};
                end else if (hdr_pos == dqne_pkg::OFS_PORT_LO) begin
                    dst_port = {dst_port[15:8], b};
                    dns_match = (dst_port == cfg_port);
                end
                hdr_pos++;
                if (hdr_pos >= dqne_pkg::UDP_HDR_BYTES) begin
                    hdr_pos = '0;
                    parse_state = dns_match ? ST_DNSHDR : ST_DONE;
                end
            end
            ST_DNSHDR: begin
                if (hdr_pos == dqne_pkg::OFS_QD_HI)
                    questions_pending = {b, 8'h00};
                else if (hdr_pos == dqne_pkg::OFS_QD_LO)
                    questions_pending = {questions_pending[15:8], b};
                hdr_pos++;
                if (hdr_pos >= dqne_pkg::DNS_HDR_BYTES) begin
                    hdr_pos = '0;
                    label_count = '0;
                    parse_state = (questions_pending != 16'd0) ? ST_LABEL_LEN : ST_DONE;
                end
            end
            ST_LABEL_LEN: begin
                if (b == 8'd0) begin
                    hdr_pos = '0;
                    parse_state = ST_QTAIL;
                end else begin
                    label_bytes_left = b;
                    if (label_count > 4'd0 && label_count < cfg_max_labels) begin
                        emit = 1'b1;
                        ch = dqne_pkg::CHAR_DOT;
                    end
                    parse_state = ST_LABEL_BODY;
                end
            end
            ST_LABEL_BODY: begin
                if (label_count < cfg_max_labels) begin
                    emit = 1'b1;
                    ch = b;
                end
                label_bytes_left--;
                if (label_bytes_left == 8'd0) begin
                    if (label_count < dqne_pkg::LABELS_CAP)
                        label_count++;
                    parse_state = ST_LABEL_LEN;
                end
            end
            ST_QTAIL: begin
                hdr_pos++;
                if (hdr_pos >= dqne_pkg::TAIL_BYTES) begin
                    hdr_pos = '0;
                    label_count = '0;
                    questions_pending--;
                    if (questions_pending != 16'd0) begin
                        emit = 1'b1;
                        ch = dqne_pkg::CHAR_SLASH;
                        parse_state = ST_LABEL_LEN;
                    end else begin
                        parse_state = ST_DONE;
                    end
                end
            end
            default: ;
        endcase
        if (emit) begin
            r = '0;
            r.char_value = ch;
            expected_results_q.push_back(r);
        end
        if (eof) begin
            r = '0;
            r.kind = 1'b1;
            r.is_dns = dns_match;
            r.ip_version = ip_ver;
            r.byte_total = bytes_seen[dqne_pkg::OUT_TOTAL_W-1:0];
            r.last = 1'b1;
            expected_results_q.push_back(r);
            // Everything but the byte total starts afresh with the next frame.
            parse_state = ST_LINK;
            hdr_pos = '0;
            hdr_len = '0;
            proto_next = '0;
            ip_ver = '0;
            dst_port = '0;
            questions_pending = '0;
            label_bytes_left = '0;
            label_count = '0;
            dns_match = 1'b0;
        end
    endtask

    function automatic t_frame_spec make_spec(
        input logic [3:0] ver, input logic [3:0] ihl, input int n_ext,
        input logic [7:0] proto, input logic [15:0] port, input logic [15:0] qd,
        input int n_names, input int n_labels, input int len_lo, input int len_hi,
        input int cut);
        t_frame_spec f;
        f.ver = ver;
        f.ihl = ihl;
        f.n_ext = n_ext;
        f.proto = proto;
        f.port = port;
        f.qd = qd;
        f.n_names = n_names;
        f.n_labels = n_labels;
        f.len_lo = len_lo;
        f.len_hi = len_hi;
        f.cut = cut;
        return f;
    endfunction

    // Builds one captured frame from a spec and appends its beats to the send queue.
    task automatic queue_frame(input t_frame_spec f);
        logic [7:0] fb[$];
        logic [7:0] nxt;
        int         ip_len;
        int         ext_base;
        int         ext_len;
        int         nl;
        int         ll;
        for (int i = 0; i < cfg_link; i++)
            fb.push_back(8'($urandom_range(255)));
        if (f.ver == dqne_pkg::IP_VER6) begin
            ext_base = $urandom_range(4);
            nxt = (f.n_ext > 0) ? ext_code(ext_base) : f.proto;
            fb.push_back({dqne_pkg::IP_VER6, 4'($urandom_range(15))});
            for (int i = 1; i < dqne_pkg::IP6_HDR_BYTES; i++)
                fb.push_back((i == dqne_pkg::OFS_IP6_NEXT) ? nxt : 8'($urandom_range(255)));
            for (int e = 0; e < f.n_ext; e++) begin
                nxt = (e + 1 < f.n_ext) ? ext_code(ext_base + e + 1) : f.proto;
                ext_len = $urandom_range(2);
                fb.push_back(nxt);
                fb.push_back(8'(ext_len));
                for (int i = 2; i < 8 + 8 * ext_len; i++)
                    fb.push_back(8'($urandom_range(255)));
            end
        end else begin
            ip_len = (f.ihl < dqne_pkg::IHL_MIN) ? 20 : 4 * f.ihl;
            fb.push_back({f.ver, f.ihl});
            for (int i = 1; i < ip_len; i++)
                fb.push_back((i == dqne_pkg::OFS_IP4_PROTO) ? f.proto
                                                            : 8'($urandom_range(255)));
        end
        fb.push_back(8'($urandom_range(255)));
        fb.push_back(8'($urandom_range(255)));
        fb.push_back(f.port[15:8]);
        fb.push_back(f.port[7:0]);
        repeat (4) fb.push_back(8'($urandom_range(255)));
        for (int i = 0; i < dqne_pkg::DNS_HDR_BYTES; i++) begin
            if (i == dqne_pkg::OFS_QD_HI)
                fb.push_back(f.qd[15:8]);
            else if (i == dqne_pkg::OFS_QD_LO)
                fb.push_back(f.qd[7:0]);
            else
                fb.push_back(8'($urandom_range(255)));
        end
        for (int q = 0; q < f.n_names && q < f.qd; q++) begin
            if (f.n_labels >= 0)
                nl = f.n_labels;
            else if ($urandom_range(99) < 8)
                nl = 0;
            else if ($urandom_range(99) < 80)
                nl = $urandom_range(4, 1);
            else
                nl = $urandom_range(17, 5);
            for (int l = 0; l < nl; l++) begin
                ll = $urandom_range(f.len_hi, f.len_lo);
                fb.push_back(8'(ll));
                repeat (ll) fb.push_back(8'($urandom_range(255)));
            end
            fb.push_back(8'd0);
            repeat (dqne_pkg::TAIL_BYTES) fb.push_back(8'($urandom_range(255)));
        end
        repeat ($urandom_range(2)) fb.push_back(8'($urandom_range(255)));
        if (f.cut > 0)
            while (fb.size() > f.cut)
                void'(fb.pop_back());
        foreach (fb[i])
            frame_bytes_q.push_back({fb[i], i == fb.size() - 1});
        stim_bytes += fb.size();
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            dqne_pkg::CFG_WATCHED_PORT: cfg_port = val;
            dqne_pkg::CFG_LINK_BYTES:   cfg_link = val[6:0];
            dqne_pkg::CFG_MAX_LABELS:   cfg_max_labels = val[3:0];
            default: ;
        endcase
    endtask

    // Returns after every queued byte has gone in and every result has come out.
    task automatic wait_drained();
        while (accepted_bytes != stim_bytes || expected_results_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Sender: one beat at a time from the byte queue, with random gaps after beats.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                parse_frame_byte(s_axis_tdata, s_axis_tlast);
                accepted_bytes++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (frame_bytes_q.size() != 0) begin
                    cur_beat = frame_bytes_q.pop_front();
                    s_axis_tdata <= cur_beat.data;
                    s_axis_tlast <= cur_beat.eof;
                    s_axis_tvalid <= 1'b1;
                    tx_gap = draw_gap(tx_gap_pct);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    // Receiver: compares every result beat with the oldest expectation.
    always @(posedge i_clk) begin
        dqne_pkg::t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: unexpected result, expected none, got tdata %h tuser %b",
                             $time, m_axis_tdata, m_axis_tuser);
                end else begin
                    want = expected_results_q.pop_front();
                    check_field("kind", 64'(want.kind), 64'(m_axis_tuser));
                    check_field("char_value", 64'(want.char_value), 64'(m_axis_tdata[7:0]));
                    check_field("is_dns", 64'(want.is_dns), 64'(m_axis_tdata[8]));
                    check_field("ip_version", 64'(want.ip_version),
                                64'(m_axis_tdata[12:9]));
                    check_field("byte_total", 64'(want.byte_total),
                                64'(m_axis_tdata[60:13]));
                    check_field("tdata padding", 64'd0, 64'(m_axis_tdata[63:61]));
                    check_field("last", 64'(want.last), 64'(m_axis_tlast));
                end
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                rx_stall = draw_gap(rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: watchdog, no beat moved for %0d cycles", $time, idle_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        int         phase_start;
        int         n;
        logic [7:0] nb;
        logic [3:0] ver;
        logic [15:0] qd;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under the reset register values.
        queue_frame(make_spec(IP_VER4, 4'd5, 0, dqne_pkg::PROTO_UDP, cfg_port, 16'd2, 2, 2,
                              1, 4, 0));
        queue_frame(make_spec(IP_VER4, 4'd5, 0, dqne_pkg::PROTO_UDP, cfg_port, 16'd1, 1, 7,
                              1, 2, 0));
        queue_frame(make_spec(IP_VER4, 4'd3, 0, dqne_pkg::PROTO_UDP, cfg_port, 16'd1, 1, 1,
                              1, 3, 0));
        queue_frame(make_spec(IP_VER4, 4'd15, 0, dqne_pkg::PROTO_UDP, cfg_port, 16'd1, 1, 1,
                              1, 3, 0));
        queue_frame(make_spec(dqne_pkg::IP_VER6, 4'd0, 0, dqne_pkg::PROTO_UDP, cfg_port,
                              16'd1, 1, 2, 1, 3, 0));
        queue_frame(make_spec(dqne_pkg::IP_VER6, 4'd0, 5, dqne_pkg::PROTO_UDP, cfg_port,
                              16'd1, 1, 1, 1, 3, 0));
        queue_frame(make_spec(4'd0, 4'd5, 0, dqne_pkg::PROTO_UDP, cfg_port, 16'd1, 1, 1,
                              1, 3, 0));
        queue_frame(make_spec(4'd15, 4'd5, 0, dqne_pkg::PROTO_UDP, cfg_port, 16'd1, 1, 1,
                              1, 3, 0));
        queue_frame(make_spec(IP_VER4, 4'd5, 0, PROTO_TCP, cfg_port, 16'd1, 1, 1, 1, 3, 0));
        queue_frame(make_spec(IP_VER4, 4'd5, 0, dqne_pkg::PROTO_UDP, cfg_port + 16'd1,
                              16'd1, 1, 1, 1, 3, 0));
        queue_frame(make_spec(IP_VER4, 4'd5, 0, dqne_pkg::PROTO_UDP, cfg_port, 16'd0, 0, 1,
                              1, 3, 0));
        // A huge question count runs into the frame end after one name.
        queue_frame(make_spec(IP_VER4, 4'd5, 0, dqne_pkg::PROTO_UDP, cfg_port, 16'hFFFF, 1,
                              1, 1, 3, 0));
        queue_frame(make_spec(IP_VER4, 4'd5, 0, dqne_pkg::PROTO_UDP, cfg_port, 16'd1, 1, 1,
                              255, 255, 0));
        queue_frame(make_spec(IP_VER4, 4'd5, 0, dqne_pkg::PROTO_UDP, cfg_port, 16'd2, 2, 0,
                              1, 3, 0));
        queue_frame(make_spec(IP_VER4, 4'd5, 0, dqne_pkg::PROTO_UDP, cfg_port, 16'd1, 1, 1,
                              1, 3, 1));
        queue_frame(make_spec(IP_VER4, 4'd5, 0, dqne_pkg::PROTO_UDP, cfg_port, 16'd1, 1, 3,
                              8, 8, 59));
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(dqne_pkg::CFG_WATCHED_PORT, 16'd0);
                    write_reg(dqne_pkg::CFG_LINK_BYTES, 16'd0);
                    write_reg(dqne_pkg::CFG_MAX_LABELS, 16'd0);
                end
                1: begin
                    write_reg(dqne_pkg::CFG_WATCHED_PORT, 16'hFFFF);
                    write_reg(dqne_pkg::CFG_LINK_BYTES, 16'd64);
                    write_reg(dqne_pkg::CFG_MAX_LABELS, 16'd15);
                end
                2: begin
                    write_reg(dqne_pkg::CFG_WATCHED_PORT, 16'($urandom_range(16'hFFFF)));
                    write_reg(dqne_pkg::CFG_LINK_BYTES, 16'd127);
                    write_reg(dqne_pkg::CFG_MAX_LABELS, 16'd1);
                end
                default: begin
                    write_reg(dqne_pkg::CFG_WATCHED_PORT, 16'($urandom_range(16'hFFFF)));
                    write_reg(dqne_pkg::CFG_LINK_BYTES,
                              ($urandom_range(9) < 7) ? 16'($urandom_range(20))
                                                      : 16'($urandom_range(127)));
                    write_reg(dqne_pkg::CFG_MAX_LABELS, 16'($urandom_range(15)));
                end
            endcase
            case (ph % 4)
                0: begin tx_gap_pct = 10; rx_stall_pct = 30; end
                1: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                2: begin tx_gap_pct = 40; rx_stall_pct = 10; end
                default: begin tx_gap_pct = 5; rx_stall_pct = 50; end
            endcase
            phase_start = stim_bytes;
            while (stim_bytes - phase_start < 30) begin
                if ($urandom_range(99) < 10) begin
                    // Raw noise frame.
                    n = $urandom_range(60, 1);
                    for (int i = 0; i < n; i++) begin
                        nb = 8'($urandom_range(255));
                        frame_bytes_q.push_back({nb, i == n - 1});
                    end
                    stim_bytes += n;
                end else begin
                    if ($urandom_range(99) < 70)
                        ver = IP_VER4;
                    else if ($urandom_range(99) < 75)
                        ver = dqne_pkg::IP_VER6;
                    else
                        ver = 4'($urandom_range(15));
                    if ($urandom_range(99) < 75)
                        qd = 16'($urandom_range(3, 1));
                    else if ($urandom_range(1) == 0)
                        qd = 16'd0;
                    else
                        qd = 16'($urandom_range(16'hFFFF));
                    queue_frame(make_spec(
                        ver,
                        ($urandom_range(99) < 80) ? dqne_pkg::IHL_MIN : 4'($urandom_range(15)),
                        $urandom_range(3),
                        ($urandom_range(99) < 88) ? dqne_pkg::PROTO_UDP
                                                  : 8'($urandom_range(255)),
                        ($urandom_range(99) < 85) ? cfg_port : 16'($urandom_range(16'hFFFF)),
                        qd,
                        (qd > 3) ? $urandom_range(2) : qd,
                        -1,
                        1,
                        ($urandom_range(99) < 5) ? 255 : 12,
                        ($urandom_range(99) < 12) ? $urandom_range(80, 1) : 0));
                end
            end
            wait_drained();
        end

        if (mismatch_count == 0 && expected_results_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
